// ----- sv/rlewd_pkg.sv -----
// ----------------------------------------------------------------------------
// rlewd_pkg: shared types and constants for the run-length word decoder
// Field widths, status codes, register indexes and the parser state record.
// ----------------------------------------------------------------------------
package rlewd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned LenW    = 9;
  localparam int unsigned ExpW    = 17;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 2;

  // Largest unit count that the expected-size register can hold.
  localparam int unsigned ExpMax = (1 << ExpW) - 1;

  localparam logic [PhaseW-1:0] UnitBytesNarrow = PhaseW'(4);
  localparam logic [PhaseW-1:0] UnitBytesWide   = PhaseW'(8);

  localparam int unsigned DefaultMaxUnits = 65536;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [IndexW-1:0] {
    REG_UNIT_MODE      = 2'd0,
    REG_EXPECTED_UNITS = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [PhaseW-1:0] byte_phase;
    logic [ByteW-1:0]  held_count;
    logic [ValueW-1:0] value_shift;
    status_t           error_code;
  } parse_state_t;

  typedef struct packed {
    logic              run_valid;
    logic [ValueW-1:0] run_value;
    logic [LenW-1:0]   run_length;
    logic              stream_done;
    status_t           status;
  } run_result_t;

endpackage

// ----- sv/rlewd_step.sv -----
// ----------------------------------------------------------------------------
// rlewd_step: record parser and unit accounting for one stream byte
// Works out the next parser state, the units still owed and the result beat.
// ----------------------------------------------------------------------------
module rlewd_step #(
  parameter int unsigned UNITS_W = 17
) (
  input  rlewd_pkg::parse_state_t state,
  input  logic [UNITS_W-1:0]      units_left,
  input  logic [UNITS_W-1:0]      units_load,
  input  logic                    unit_mode,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output rlewd_pkg::parse_state_t state_next,
  output logic [UNITS_W-1:0]      units_next,
  output rlewd_pkg::run_result_t  result
);
  import rlewd_pkg::*;

  logic [PhaseW-1:0] unit_bytes;
  logic [2:0]        slot;
  logic [LenW-1:0]   count;
  logic              complete;
  logic              fits;
  logic [ExpW-1:0]   units_wide;
  logic [ExpW-1:0]   units_diff;
  parse_state_t      parsed;
  logic [UNITS_W-1:0] units_parsed;
  logic              run;

  assign unit_bytes = unit_mode ? UnitBytesWide : UnitBytesNarrow;
  assign slot       = 3'(state.byte_phase - PhaseW'(1));
  assign count      = LenW'(state.held_count) + LenW'(1);
  // A mode change mid-record may leave the phase beyond the new unit size.
  assign complete   = (state.byte_phase != '0) && (state.byte_phase >= unit_bytes);
  assign units_wide = ExpW'(units_left);
  assign fits       = ExpW'(count) <= units_wide;
  assign units_diff = units_wide - ExpW'(count);

  always_comb begin
    parsed       = state;
    units_parsed = units_left;
    run          = 1'b0;
    if (state.byte_phase == '0) begin
      parsed.held_count  = data_byte;
      parsed.value_shift = '0;
      parsed.byte_phase  = PhaseW'(1);
    end else begin
      parsed.value_shift = state.value_shift | (ValueW'(data_byte) << {slot, 3'b000});
      if (complete) begin
        parsed.byte_phase = '0;
        if (state.error_code == ST_OK) begin
          if (fits) begin
            units_parsed = UNITS_W'(units_diff);
            run          = 1'b1;
          end else begin
            parsed.error_code = ST_OVERFLOW;
          end
        end
      end else begin
        parsed.byte_phase = state.byte_phase + PhaseW'(1);
      end
    end
  end

  always_comb begin
    result.run_valid   = run;
    result.run_value   = '0;
    result.run_length  = '0;
    result.stream_done = last_byte;
    result.status      = ST_OK;
    if (run) begin
      result.run_value  = unit_mode ? parsed.value_shift
                                    : {32'd0, parsed.value_shift[31:0]};
      result.run_length = count;
    end
    if (last_byte) begin
      if (parsed.byte_phase != '0) begin
        result.status = ST_PARTIAL;
      end else if (parsed.error_code == ST_OVERFLOW) begin
        result.status = ST_OVERFLOW;
      end else if (units_parsed != '0) begin
        result.status = ST_UNDERFLOW;
      end else begin
        result.status = ST_OK;
      end
    end
  end

  // The final byte rearms the parser for the next stream.
  always_comb begin
    if (last_byte) begin
      state_next.byte_phase  = '0;
      state_next.held_count  = '0;
      state_next.value_shift = '0;
      state_next.error_code  = ST_OK;
      units_next             = units_load;
    end else begin
      state_next = parsed;
      units_next = units_parsed;
    end
  end

endmodule

// ----- sv/rle_word_decoder.sv -----
// ----------------------------------------------------------------------------
// rle_word_decoder: byte-serial run-length decoder for 4- or 8-byte units
// Parses count/unit records, emits run descriptors and an end-of-stream status.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid, in_stall  | data_byte, last_byte
//  output   | out_valid, out_stall| run_valid, run_value, run_length,
//           |                     | stream_done, status
//  config   | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// One byte is accepted per cycle while the input is not stalled; its result
// beat, if any, appears in the output register on the following cycle. The
// parser state is updated in the same cycle as the byte is taken.
// The input is stalled only while a result beat is held and the output stalls.
// Reset clears the parser, the registers and the output valid flag; the
// configuration port is always ready.
module rle_word_decoder #(
  parameter int unsigned MAX_OUTPUT_UNITS = rlewd_pkg::DefaultMaxUnits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          run_valid,
  output logic [63:0]                   run_value,
  output logic [8:0]                    run_length,
  output logic                          stream_done,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlewd_pkg::IndexW-1:0]  cfg_index,
  input  logic [rlewd_pkg::ExpW-1:0]    cfg_data
);
  import rlewd_pkg::*;

  localparam int unsigned LoadMax = (MAX_OUTPUT_UNITS > ExpMax) ? ExpMax : MAX_OUTPUT_UNITS;
  localparam int unsigned UnitsW  = $clog2(LoadMax + 1);

  logic                unit_mode;
  logic [ExpW-1:0]     expected_units;
  parse_state_t        state;
  parse_state_t        state_next;
  logic [UnitsW-1:0]   units_left;
  logic [UnitsW-1:0]   units_next;
  logic [UnitsW-1:0]   units_load;
  logic [UnitsW-1:0]   cfg_units;
  run_result_t         result;
  run_result_t         out_reg;
  logic                accept;
  logic                cfg_write;

  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  assign units_load = (expected_units > ExpW'(LoadMax)) ? UnitsW'(LoadMax)
                                                        : UnitsW'(expected_units);
  assign cfg_units  = (cfg_data > ExpW'(LoadMax)) ? UnitsW'(LoadMax) : UnitsW'(cfg_data);

  rlewd_step #(
    .UNITS_W (UnitsW)
  ) u_step (
    .state      (state),
    .units_left (units_left),
    .units_load (units_load),
    .unit_mode  (unit_mode),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .state_next (state_next),
    .units_next (units_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode      <= 1'b0;
      expected_units <= '0;
      state          <= '0;
      units_left     <= '0;
    end else begin
      if (accept) begin
        state      <= state_next;
        units_left <= units_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_UNIT_MODE: begin
            unit_mode <= cfg_data[0];
          end
          REG_EXPECTED_UNITS: begin
            expected_units <= cfg_data;
            units_left     <= cfg_units;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // A byte that completes no record and is not the last gives no beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result.run_valid | result.stream_done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign run_valid   = out_reg.run_valid;
  assign run_value   = out_reg.run_value;
  assign run_length  = out_reg.run_length;
  assign stream_done = out_reg.stream_done;
  assign status      = out_reg.status;

  a_beat_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_valid | stream_done))
    else $error("output beat carries neither a run nor an end of stream");

  a_run_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid & run_valid) |-> (run_length != '0))
    else $error("run emitted with zero length");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept & last_byte & ~(cfg_write)) |=> (state.byte_phase == '0 &&
                                            state.error_code == ST_OK))
    else $error("parser not rearmed after the last byte");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the run-length word decoder
// Feeds record streams byte by byte with random gaps and output stalls,
// predicts every run and end-of-stream beat, and compares them field by field.
// ----------------------------------------------------------------------------
import rlewd_pkg::*;

class run_checker;
  bit                wide_mode;
  logic [ExpW-1:0]   exp_units;
  logic [PhaseW-1:0] phase;
  logic [ByteW-1:0]  count_byte;
  logic [ValueW-1:0] unit_acc;
  logic [ExpW-1:0]   units_left;
  status_t           err;
  run_result_t       owed_runs[$];
  int unsigned       fails;

  function new();
    wide_mode = 1'b0;
    exp_units = '0;
    fails     = 0;
    rearm();
  endfunction

  function logic [ExpW-1:0] clamped();
    return (exp_units > DefaultMaxUnits) ? ExpW'(DefaultMaxUnits) : exp_units;
  endfunction

  function void rearm();
    phase      = '0;
    count_byte = '0;
    unit_acc   = '0;
    err        = ST_OK;
    units_left = clamped();
  endfunction

  function void set_reg(reg_index_t idx, logic [ExpW-1:0] val);
    if (idx == REG_UNIT_MODE) begin
      wide_mode = val[0];
    end else if (idx == REG_EXPECTED_UNITS) begin
      exp_units  = val;
      units_left = clamped();
    end
  endfunction

  function int pending();
    return owed_runs.size();
  endfunction

  // Advances the parser by one accepted byte and queues the beat it owes.
  function void take_byte(logic [ByteW-1:0] b, logic lst);
    logic [PhaseW-1:0] unit_bytes;
    logic [LenW-1:0]   reps;
    int unsigned       k;
    run_result_t       r;
    bit                emit;
    unit_bytes = wide_mode ? UnitBytesWide : UnitBytesNarrow;
    r    = '0;
    emit = 1'b0;
    if (phase == 0) begin
      count_byte = b;
      unit_acc   = '0;
      phase      = PhaseW'(1);
    end else begin
      k = (int'(phase) - 1) & 7;
      unit_acc = unit_acc | (ValueW'(b) << (8 * k));
      // A mode change mid-record completes it as soon as the phase is far enough.
      if (phase >= unit_bytes) begin
        reps  = LenW'(count_byte) + LenW'(1);
        phase = '0;
        if (err == ST_OK) begin
          if (ExpW'(reps) > units_left) begin
            err = ST_OVERFLOW;
          end else begin
            units_left   = units_left - ExpW'(reps);
            emit         = 1'b1;
            r.run_valid  = 1'b1;
            r.run_value  = wide_mode ? unit_acc : {32'h0, unit_acc[31:0]};
            r.run_length = reps;
          end
        end
      end else begin
        phase = phase + PhaseW'(1);
      end
    end
    if (emit || lst) begin
      if (lst) begin
        r.stream_done = 1'b1;
        if (phase != 0)               r.status = ST_PARTIAL;
        else if (err == ST_OVERFLOW)  r.status = ST_OVERFLOW;
        else if (units_left != 0)     r.status = ST_UNDERFLOW;
        else                          r.status = ST_OK;
        rearm();
      end
      owed_runs.push_back(r);
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fails++;
  endtask

  task check_beat(run_result_t got);
    run_result_t want;
    if (owed_runs.size() == 0) begin
      report($sformatf("unexpected beat %h", got));
      return;
    end
    want = owed_runs.pop_front();
    if (got.run_valid !== want.run_valid)
      report($sformatf("run_valid %0b, wanted %0b", got.run_valid, want.run_valid));
    if (got.run_value !== want.run_value)
      report($sformatf("run_value %h, wanted %h", got.run_value, want.run_value));
    if (got.run_length !== want.run_length)
      report($sformatf("run_length %0d, wanted %0d", got.run_length, want.run_length));
    if (got.stream_done !== want.stream_done)
      report($sformatf("stream_done %0b, wanted %0b", got.stream_done, want.stream_done));
    if (got.status !== want.status)
      report($sformatf("status %0d, wanted %0d", got.status, want.status));
  endtask
endclass

module tb_top;

  typedef enum int {SK_OK, SK_UNDER, SK_OVER, SK_PARTIAL, SK_NOISE} stream_kind_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic              run_valid;
  logic [63:0]       run_value;
  logic [8:0]        run_length;
  logic              stream_done;
  logic [1:0]        status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IndexW-1:0] cfg_index;
  logic [ExpW-1:0]   cfg_data;

  run_checker  sb;
  logic [8:0]  stream_q[$];   // {last, byte}
  bit          cur_wide;
  int unsigned cur_exp;
  int unsigned sent;
  int unsigned in_gap_pct;
  int unsigned out_gap_pct;

  rle_word_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .run_valid   (run_valid),
    .run_value   (run_value),
    .run_length  (run_length),
    .stream_done (stream_done),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL rle_word_decoder");
    $finish;
  end

  // Result side: random stall bursts, then checking of every accepted beat.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_gap_pct != 0 && $urandom_range(0, 99) < out_gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_beat({run_valid, run_value, run_length, stream_done, status});
  end

  function automatic int unsigned pick_reps(int unsigned limit);
    int unsigned cap;
    cap = (limit > 256) ? 256 : limit;
    case ($urandom_range(0, 3))
      0:       return cap;
      1:       return 1;
      default: return $urandom_range(1, cap);
    endcase
  endfunction

  function automatic void add_record(int unsigned reps, logic [63:0] val);
    stream_q.push_back({1'b0, 8'(reps - 1)});
    for (int i = 0; i < (cur_wide ? 8 : 4); i++)
      stream_q.push_back({1'b0, val[8*i +: 8]});
  endfunction

  function automatic void consume(int unsigned total);
    int unsigned reps;
    while (total != 0) begin
      reps = pick_reps(total);
      add_record(reps, {$urandom, $urandom});
      total -= reps;
    end
  endfunction

  function automatic void build_stream(stream_kind_t kind);
    int unsigned left;
    int unsigned extra;
    left = (cur_exp > DefaultMaxUnits) ? DefaultMaxUnits : cur_exp;
    // Large totals would need hundreds of records, so steer those streams elsewhere.
    if (left > 1500 && kind == SK_OK) kind = SK_UNDER;
    if (left > 1500 && kind == SK_OVER) kind = SK_PARTIAL;
    if (left < 2 && kind == SK_UNDER) kind = SK_OVER;
    if (left == 0 && kind == SK_OK) kind = SK_OVER;
    stream_q.delete();
    case (kind)
      SK_OK:    consume(left);
      SK_UNDER: consume($urandom_range(1, (left - 1 > 1000) ? 1000 : left - 1));
      SK_OVER: begin
        extra = $urandom_range(0, (left > 255) ? 255 : left);
        consume(left - extra);
        add_record($urandom_range(extra + 1, 256), {$urandom, $urandom});
        repeat ($urandom_range(0, 3)) add_record(pick_reps(256), {$urandom, $urandom});
      end
      SK_PARTIAL: begin
        repeat ($urandom_range(0, 2)) add_record(pick_reps(256), {$urandom, $urandom});
        stream_q.push_back({1'b0, 8'($urandom)});
        repeat ($urandom_range(0, cur_wide ? 7 : 3)) stream_q.push_back({1'b0, 8'($urandom)});
      end
      default: repeat ($urandom_range(1, 24)) stream_q.push_back({1'b0, 8'($urandom)});
    endcase
  endfunction

  task automatic send_byte(input logic [8:0] item);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= item[7:0];
    last_byte <= item[8];
    do @(posedge clk); while (in_stall);
    sb.take_byte(item[7:0], item[8]);
    sent++;
  endtask

  // Registers change only once every owed beat is out and the pipe has settled.
  task automatic write_reg(input reg_index_t idx, input logic [ExpW-1:0] val);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    if (idx == REG_UNIT_MODE) cur_wide = val[0];
    else cur_exp = val;
  endtask

  task automatic send_stream(input bit split);
    int cut;
    stream_q[stream_q.size() - 1][8] = 1'b1;
    cut = (split && stream_q.size() > 1) ? $urandom_range(1, stream_q.size() - 1) : -1;
    foreach (stream_q[i]) begin
      // A register write part-way through a stream, often in the middle of a record.
      if (i == cut) begin
        if ($urandom_range(0, 1))
          write_reg(REG_UNIT_MODE, {16'($urandom), !cur_wide});
        else
          write_reg(REG_EXPECTED_UNITS, ExpW'($urandom_range(0, 600)));
      end
      send_byte(stream_q[i]);
    end
  endtask

  initial begin
    int unsigned  rand_end;
    int unsigned  r;
    int unsigned  e;
    int unsigned  n;
    bit           quiet;
    stream_kind_t kind;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= '0;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_UNIT_MODE;
    cfg_data  <= '0;
    cur_wide    = 1'b0;
    cur_exp     = 0;
    sent        = 0;
    in_gap_pct  = 10;
    out_gap_pct = 10;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset nothing is owed, so any record overflows.
    stream_q.delete();
    add_record(1, 64'h0000_0000_00FF_00FF);
    send_stream(1'b0);

    // Longest and shortest repeats; the final run shares its beat with the status.
    write_reg(REG_UNIT_MODE, '0);
    write_reg(REG_EXPECTED_UNITS, ExpW'(257));
    stream_q.delete();
    add_record(256, 64'h0000_0000_FFFF_FFFF);
    add_record(1, 64'h0);
    send_stream(1'b0);

    // Wide units, in a stream that ends on a lone count byte.
    write_reg(REG_UNIT_MODE, '1);
    write_reg(REG_EXPECTED_UNITS, ExpW'(5));
    stream_q.delete();
    add_record(5, '1);
    stream_q.push_back({1'b0, 8'h00});
    send_stream(1'b0);

    // The largest register value is clamped, and two full runs leave units owed.
    in_gap_pct  = 5;
    out_gap_pct = 5;
    write_reg(REG_UNIT_MODE, ExpW'('h1FFFE));
    write_reg(REG_EXPECTED_UNITS, '1);
    stream_q.delete();
    repeat (2) add_record(256, {$urandom, $urandom});
    send_stream(1'b0);

    rand_end = sent + 800;
    while (sent < rand_end) begin
      quiet = (sent + 150 >= rand_end);
      case ($urandom_range(0, 3))
        0:       in_gap_pct = 0;
        1:       in_gap_pct = 3;
        2:       in_gap_pct = 15;
        default: in_gap_pct = 40;
      endcase
      case ($urandom_range(0, 3))
        0:       out_gap_pct = 0;
        1:       out_gap_pct = 3;
        2:       out_gap_pct = 15;
        default: out_gap_pct = 40;
      endcase
      if (quiet) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      r = $urandom_range(0, 9);
      if (r < 7)       e = $urandom_range(0, 700);
      else if (r == 7) e = 0;
      else if (r == 8) e = $urandom_range(65537, 131071);
      else             e = DefaultMaxUnits;
      write_reg(REG_EXPECTED_UNITS, ExpW'(e));
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_UNIT_MODE, {16'($urandom), 1'($urandom)});
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 19);
        if (r < 11)      kind = SK_OK;
        else if (r < 14) kind = SK_UNDER;
        else if (r < 16) kind = SK_OVER;
        else if (r < 18) kind = SK_PARTIAL;
        else             kind = SK_NOISE;
        build_stream(kind);
        send_stream(!quiet && $urandom_range(0, 9) == 0);
      end
    end

    in_valid <= 1'b0;
    n = 0;
    while (sb.pending() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d beats never arrived", sb.pending()));
    if (sb.fails == 0) begin
      $display("PASS rle_word_decoder");
    end else begin
      $display("FAIL rle_word_decoder");
    end
    $finish;
  end

endmodule

// ----- rle_word_decoder.f -----
sv/rlewd_pkg.sv
sv/rlewd_step.sv
sv/rle_word_decoder.sv
sim/tb_top.sv
